// File: hw/rtl/nqshc_pkg.sv
// Shared types and constants of the N-queens swap hill climber.
package nqshc_pkg;

  localparam int MODE_W  = 2;
  localparam int ROW_W   = 11;
  localparam int SIZE_W  = 11;
  localparam int LIMIT_W = 23;
  localparam int FAIL_W  = 22;
  localparam int TOTAL_W = 11;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1024);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32768);

  localparam logic [ADDR_W-1:0] REG_BOARD_SIZE  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_TRIAL_LIMIT = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESTART = 2'd0,
    MODE_FORCED  = 2'd1,
    MODE_TRIAL   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

endpackage

// File: hw/rtl/nqshc_if.sv
// Request and response channel interfaces.
interface nqshc_req_if import nqshc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  row_a;
  logic [ROW_W-1:0]  row_b;
  modport source (output valid, mode, row_a, row_b, input ready);
  modport sink   (input valid, mode, row_a, row_b, output ready);
endinterface

interface nqshc_rsp_if import nqshc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] conflict_total;
  logic               accepted;
  logic               exhausted;
  logic               solved;
  logic               rejected;
  modport source (output valid, conflict_total, accepted, exhausted, solved, rejected,
                  input ready);
  modport sink   (input valid, conflict_total, accepted, exhausted, solved, rejected,
                  output ready);
endinterface

// File: hw/rtl/n_queens_swap_hill_climb_unit.sv
// N-queens swap hill climber: top level with board, diagonal counters and sequencer.
// Restart: one sweep over the counter memories before the response.
// A trial swap not kept runs a second pass to revert; rejected or mode 3 skip the swap.
// Each swap runs eight read-modify-write steps on one shared counter update unit.
// One request at a time; the result register frees the request side.
// rst clears control state; counter memories hold garbage until the first restart.
module n_queens_swap_hill_climb_unit import nqshc_pkg::*; #(
  parameter int MAX_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  nqshc_req_if.sink          req,
  nqshc_rsp_if.source        rsp
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_ROWS);
  localparam int DW = CW + 1;
  localparam int EW = DW + 1;
  localparam int TW = RW + 1;
  localparam int XW = (RW > ROW_W) ? RW : ROW_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_ROWS);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLEAR  = 10'b0000000010,
    S_LOAD_A = 10'b0000000100,
    S_LOAD_B = 10'b0000001000,
    S_LOAD_C = 10'b0000010000,
    S_OP_RD  = 10'b0000100000,
    S_OP_WR  = 10'b0001000000,
    S_WR_A   = 10'b0010000000,
    S_WR_B   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]  board_size;
  logic [LIMIT_W-1:0] trial_limit;
  logic [RW-1:0]      n;
  logic [RW-1:0]      row_r;
  logic [RW-1:0]      row_s;
  logic [CW-1:0]      col_r;
  logic [CW-1:0]      col_s;
  logic [TW-1:0]      total;
  logic [TW-1:0]      total_prev;
  logic [FAIL_W-1:0]  failed;
  logic               board_ready;
  logic               trial;
  logic               pass;
  logic [2:0]         k;
  logic [DW-1:0]      sweep;
  logic               acc_f;
  logic               exh_f;
  logic               rej_f;

  logic [RW-1:0] rising [2*MAX_ROWS];
  logic [RW-1:0] falling [2*MAX_ROWS];
  logic [CW-1:0] column [MAX_ROWS];
  logic [RW-1:0] rise_q;
  logic [RW-1:0] fall_q;
  logic [CW-1:0] col_q;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size  <= SIZE_RESET;
      trial_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr == REG_BOARD_SIZE) board_size <= pwdata[SIZE_W-1:0];
      if (paddr == REG_TRIAL_LIMIT) trial_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_BOARD_SIZE:  prdata = DATA_W'(board_size);
      REG_TRIAL_LIMIT: prdata = DATA_W'(trial_limit);
      default:         prdata = '0;
    endcase
  end

  // request decode
  logic [XW-1:0] bs_x;
  logic [XW-1:0] n_sat;
  logic [XW-1:0] ra_x;
  logic [XW-1:0] rb_x;
  logic [XW-1:0] n_x;
  logic          reject;
  logic          take;

  assign bs_x   = XW'(board_size);
  assign n_sat  = (bs_x > MAX_X) ? MAX_X : bs_x;
  assign ra_x   = XW'(req.row_a);
  assign rb_x   = XW'(req.row_b);
  assign n_x    = XW'(n);
  assign reject = !board_ready || ra_x == '0 || rb_x == '0 || ra_x > n_x || rb_x > n_x;
  assign req.ready = (state == S_IDLE);
  assign take   = req.valid && req.ready;

  // shared counter update unit
  logic          is_rising;
  logic          is_up;
  logic [RW-1:0] row_sel;
  logic [CW-1:0] col_sel;
  logic [EW-1:0] idx_e;
  logic [DW-1:0] idx;
  logic [RW-1:0] cnt;
  logic [RW-1:0] cnt_next;
  logic [TW-1:0] total_next;

  assign is_rising = !k[1];
  assign is_up     = k[0];
  assign row_sel   = k[2] ? row_s : row_r;
  assign col_sel   = (k[0] ^ k[2]) ? col_s : col_r;
  assign idx_e     = is_rising ? EW'(row_sel) + EW'(n) - EW'(col_sel) - EW'(1)
                               : EW'(row_sel) + EW'(col_sel);
  assign idx       = idx_e[DW-1:0];
  assign cnt       = is_rising ? rise_q : fall_q;

  always_comb begin
    cnt_next   = cnt;
    total_next = total;
    if (is_up) begin
      cnt_next = cnt + RW'(1);
      if (cnt != '0) total_next = total + TW'(1);
    end else if (cnt != '0) begin
      cnt_next = cnt - RW'(1);
      if (cnt != RW'(1)) total_next = total - TW'(1);
    end
  end

  // memories
  logic          clearing;
  logic          rise_we;
  logic          fall_we;
  logic [DW-1:0] diag_waddr;
  logic [RW-1:0] rise_wdata;
  logic [RW-1:0] fall_wdata;
  logic          col_we;
  logic [CW-1:0] col_waddr;
  logic [CW-1:0] col_wdata;
  logic [CW-1:0] col_raddr;
  logic [EW-1:0] sweep_e;

  assign clearing   = (state == S_CLEAR);
  assign sweep_e    = EW'(sweep);
  assign rise_we    = clearing || (state == S_OP_WR && is_rising);
  assign fall_we    = clearing || (state == S_OP_WR && !is_rising);
  assign diag_waddr = clearing ? sweep : idx;
  assign rise_wdata = clearing ? ((sweep_e == EW'(n)) ? n : '0) : cnt_next;
  assign fall_wdata = clearing ? RW'(sweep[0] && sweep_e < {n, 1'b0}) : cnt_next;

  always_comb begin
    col_we    = 1'b0;
    col_waddr = sweep[CW-1:0];
    col_wdata = sweep[CW-1:0];
    col_raddr = CW'(row_r - RW'(1));
    unique case (state)
      S_CLEAR: col_we = !sweep[DW-1];
      S_WR_A: begin
        col_we    = 1'b1;
        col_waddr = CW'(row_r - RW'(1));
        col_wdata = col_s;
      end
      S_WR_B: begin
        col_we    = 1'b1;
        col_waddr = CW'(row_s - RW'(1));
        col_wdata = col_r;
      end
      S_LOAD_B: col_raddr = CW'(row_s - RW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rise_we) rising[diag_waddr] <= rise_wdata;
    if (fall_we) falling[diag_waddr] <= fall_wdata;
    rise_q <= rising[idx];
    fall_q <= falling[idx];
  end

  always_ff @(posedge clk) begin
    if (col_we) column[col_waddr] <= col_wdata;
    col_q <= column[col_raddr];
  end

  // sequencer
  logic [LIMIT_W-1:0] fail_inc;
  assign fail_inc = LIMIT_W'(failed) + LIMIT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      n           <= '0;
      total       <= '0;
      failed      <= '0;
      board_ready <= 1'b0;
      rsp.valid   <= 1'b0;
      k           <= '0;
      sweep       <= '0;
      pass        <= 1'b0;
      trial       <= 1'b0;
      acc_f       <= 1'b0;
      exh_f       <= 1'b0;
      rej_f       <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            acc_f <= 1'b0;
            exh_f <= 1'b0;
            rej_f <= 1'b0;
            row_r <= RW'(req.row_a);
            row_s <= RW'(req.row_b);
            trial <= (req.mode == MODE_TRIAL);
            pass  <= 1'b0;
            k     <= '0;
            priority if (req.mode == MODE_RESTART) begin
              n           <= RW'(n_sat);
              total       <= (n_sat == '0) ? '0 : TW'(n_sat) - TW'(1);
              failed      <= '0;
              board_ready <= 1'b1;
              sweep       <= '0;
              state       <= S_CLEAR;
            end else if (req.mode == MODE_NONE) begin
              state <= S_DONE;
            end else if (reject) begin
              rej_f <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_LOAD_A;
            end
          end
        end
        S_CLEAR: begin
          sweep <= sweep + DW'(1);
          if (&sweep) state <= S_DONE;
        end
        S_LOAD_A: state <= S_LOAD_B;
        S_LOAD_B: begin
          col_r <= col_q;
          state <= S_LOAD_C;
        end
        S_LOAD_C: begin
          col_s      <= col_q;
          total_prev <= total;
          state      <= S_OP_RD;
        end
        S_OP_RD: state <= S_OP_WR;
        S_OP_WR: begin
          total <= total_next;
          k     <= k + 3'd1;
          state <= (k == 3'd7) ? S_WR_A : S_OP_RD;
        end
        S_WR_A: state <= S_WR_B;
        S_WR_B: begin
          priority if (!trial) begin
            state <= S_DONE;
          end else if (!pass && total < total_prev) begin
            acc_f  <= 1'b1;
            failed <= '0;
            state  <= S_DONE;
          end else if (!pass) begin
            col_r <= col_s;
            col_s <= col_r;
            pass  <= 1'b1;
            state <= S_OP_RD;
          end else begin
            if (fail_inc >= trial_limit) begin
              exh_f  <= 1'b1;
              failed <= '0;
            end else begin
              failed <= fail_inc[FAIL_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.conflict_total <= TOTAL_W'(total);
            rsp.accepted       <= acc_f;
            rsp.exhausted      <= exh_f;
            rsp.solved         <= board_ready && total == '0;
            rsp.rejected       <= rej_f;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/nqshc_checker.sv
// Port-level checker for the N-queens swap hill climber, bound to the top level.
module nqshc_checker import nqshc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [TOTAL_W-1:0] conflict_total,
  input logic               accepted,
  input logic               exhausted,
  input logic               solved,
  input logic               rejected
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  a_solved_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && solved |-> conflict_total == '0)
    else $error("solved with nonzero conflicts");

  a_acc_rej: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rejected |-> !accepted && !exhausted)
    else $error("rejected request reports a trial outcome");

  a_acc_exh: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && accepted |-> !exhausted)
    else $error("kept trial reports exhausted");

endmodule

bind n_queens_swap_hill_climb_unit nqshc_checker u_nqshc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .conflict_total(rsp.conflict_total),
  .accepted      (rsp.accepted),
  .exhausted     (rsp.exhausted),
  .solved        (rsp.solved),
  .rejected      (rsp.rejected)
);
